FILE: src/awd_pkg.sv
// Package for the approach warning detector: payload structs, register
// indexes, field widths and reset values of the configuration registers.
// No dependencies.
package awd_pkg;

	localparam int ADC_W     = 12;
	localparam int ELAPSED_W = 16;
	localparam int DIST_W    = 17;
	localparam int RATE_W    = 10;
	localparam int RUN_W     = 8;
	localparam int SCALE_W   = 16;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam int HISTORY_DEPTH_DEF = 5;

	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
	localparam logic [RUN_W-1:0]   RUN_MAX   = '1;

	localparam logic [DIST_W-1:0]  DIST_LIMIT_RST = 17'd12800;
	localparam logic [RATE_W-1:0]  RATE_LIMIT_RST = 10'd20;
	localparam logic [RUN_W-1:0]   READINGS_RST   = 8'd3;
	localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd20815;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIST_LIMIT = 2'd0,
		CFG_RATE_LIMIT = 2'd1,
		CFG_READINGS   = 2'd2,
		CFG_SCALE      = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [ADC_W-1:0]     adc_code;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} in_t;

	typedef struct packed {
		logic              warning;
		logic [DIST_W-1:0] distance;
		logic [RUN_W-1:0]  approach_run;
	} out_t;

endpackage

FILE: src/approach_warning_detector.sv
// Approach warning detector top level: sequencer around one shared multiplier.
// Depends on awd_pkg.
//
// Usage: an input transfer carries one converter code and the milliseconds
// since the previous sample. Each transfer yields exactly one result transfer
// with the warning flag, the distance in 1/64 cm and the approach run length.
// The input channel is stalled from the cycle after a transfer until the
// result has been written to the output register. One multiplier serves the
// code scaling, the rate threshold and the approach term, one product per
// cycle; an item passes the scale, distance, difference, product and done
// steps; the first item after reset only fills the history and skips the
// difference and product steps. The sequencer returns to idle between items.
// The result waits in an output register: while the receiver stalls, the
// result holds and the block sits in its final step, but it may already have
// accepted the item that follows. Configuration writes take effect at once;
// the user makes them while the block is idle; the block does not enforce it.
// Reset clears the sequencer, run count, ring pointer and the primed flag, and
// loads the register defaults; the first item after reset fills the history.
module approach_warning_detector #(
	parameter int HISTORY_DEPTH = awd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  awd_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output awd_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [awd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [awd_pkg::CFG_W-1:0]     cfg_data
);
	import awd_pkg::*;

	localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W   = DIST_W + 2;
	localparam int MUL_A_W = SUM_W;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int RHS_W   = RATE_W + ELAPSED_W + 8;
	localparam int LHS_W   = SUM_W + 10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_DIST,
		ST_DIFF,
		ST_LHS,
		ST_DONE
	} state_t;

	state_t              state_q;
	in_t                 in_q;
	logic [DIST_W-1:0]   dist_limit_q;
	logic [RATE_W-1:0]   rate_limit_q;
	logic [RUN_W-1:0]    readings_q;
	logic [SCALE_W-1:0]  scale_q;
	logic [DIST_W-1:0]   hist_q [HISTORY_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [RUN_W-1:0]    run_q;
	logic                primed_q;
	logic [PROD_W-1:0]   prod_q;
	logic [DIST_W-1:0]   dist_q;
	logic [RHS_W-1:0]    rhs_q;
	logic                diff_neg_q;
	logic [SUM_W-1:0]    diff_mag_q;
	logic                out_valid_q;
	out_t                out_q;

	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [SUM_W-1:0]    hist_sum;
	logic [SUM_W-1:0]    dist_x3;
	logic [SUM_W:0]      diff;
	logic [DIST_W:0]     scaled;
	logic [RHS_W-1:0]    rhs_d;
	logic                approach;
	logic [RUN_W-1:0]    run_next;
	logic                done_go;

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_SCALE: begin
				mul_a = MUL_A_W'(in_q.adc_code);
				mul_b = MUL_B_W'(scale_q);
			end
			ST_DIST: begin
				mul_a = MUL_A_W'(rate_limit_q);
				mul_b = MUL_B_W'(in_q.elapsed_ms);
			end
			ST_LHS: begin
				mul_a = diff_mag_q;
				mul_b = MUL_B_W'(1000);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign scaled   = prod_q[DIST_W+10:10];
	assign hist_sum = SUM_W'(hist_q[0]) + SUM_W'(hist_q[1]) + SUM_W'(hist_q[2]);
	assign dist_x3  = {1'b0, dist_q, 1'b0} + SUM_W'(dist_q);
	assign diff     = {1'b0, hist_sum} - {1'b0, dist_x3};
	// Threshold is rate * elapsed * 192, built as two shifted copies.
	assign rhs_d    = RHS_W'({prod_q[RHS_W-8-1:0], 7'b0})
	                + RHS_W'({1'b0, prod_q[RHS_W-8-1:0], 6'b0});

	// A sample above the mean can never reach a non-negative threshold.
	assign approach = !diff_neg_q && (RHS_W'(prod_q[LHS_W-1:0]) >= rhs_q);
	assign run_next = approach ? ((run_q == RUN_MAX) ? RUN_MAX : run_q + 1'b1) : '0;
	assign done_go  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dist_limit_q <= DIST_LIMIT_RST;
			rate_limit_q <= RATE_LIMIT_RST;
			readings_q   <= READINGS_RST;
			scale_q      <= SCALE_RST;
			slot_q       <= '0;
			run_q        <= '0;
			primed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_idx))
					CFG_DIST_LIMIT: dist_limit_q <= cfg_data;
					CFG_RATE_LIMIT: rate_limit_q <= cfg_data[RATE_W-1:0];
					CFG_READINGS:   readings_q   <= cfg_data[RUN_W-1:0];
					CFG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
					default:        ;
				endcase
			end

			if (out_valid_q && !out_stall && !done_go) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_DIST;
				ST_DIST:  state_q <= primed_q ? ST_DIFF : ST_DONE;
				ST_DIFF:  state_q <= ST_LHS;
				ST_LHS:   state_q <= ST_DONE;
				ST_DONE: begin
					if (done_go) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						if (!primed_q) begin
							primed_q <= 1'b1;
							out_q    <= '{warning: 1'b0, distance: dist_q, approach_run: run_q};
						end else begin
							run_q  <= run_next;
							slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
							out_q  <= '{warning: (dist_q < dist_limit_q) && (run_next >= readings_q),
							            distance: dist_q, approach_run: run_next};
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			in_q <= in_data;
		end
		if (state_q == ST_SCALE || state_q == ST_DIST || state_q == ST_LHS) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == ST_DIST) begin
			dist_q <= scaled[DIST_W] ? DIST_MAX : scaled[DIST_W-1:0];
		end
		if (state_q == ST_DIFF) begin
			rhs_q      <= rhs_d;
			diff_neg_q <= diff[SUM_W];
			diff_mag_q <= diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
		end
		if (done_go) begin
			if (!primed_q) begin
				for (int i = 0; i < HISTORY_DEPTH; i++) begin
					hist_q[i] <= dist_q;
				end
			end else begin
				hist_q[slot_q] <= dist_q;
			end
		end
	end

endmodule

FILE: src/awd_checker.sv
// Port-level checker for the approach warning detector, bound to the top level.
// Depends on awd_pkg and approach_warning_detector.
module awd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input awd_pkg::out_t out_data
);
	import awd_pkg::*;

	// A result that is held back stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// After an input transfer the block is busy and stalls the input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled while an item is in work");

	// A new result only appears at the end of an item's work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// An idle block with nothing pending does not raise a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !out_valid |=> !out_valid)
		else $error("result appeared while idle");

endmodule

bind approach_warning_detector awd_checker u_awd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: bench/testbench.sv
// Self-checking testbench for approach_warning_detector: directed corners, then
// random sensor sequences under changing register settings and random stalls.
// Depends on awd_pkg and the approach_warning_detector RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import awd_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int HISTORY_DEPTH = HISTORY_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	// Predictor state and register copies.
	logic [DIST_W-1:0] ring [HISTORY_DEPTH];
	int ring_slot;
	logic [RUN_W-1:0] run_len;
	bit primed;
	logic [DIST_W-1:0] lim_dist;
	logic [RATE_W-1:0] lim_rate;
	logic [RUN_W-1:0] runs_needed;
	logic [SCALE_W-1:0] scale_q16;

	out_t expected_readings [$];
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int warnings_seen = 0;
	int longest_run = 0;
	int settings_written = 0;
	int cycle_count = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_ack;

	approach_warning_detector i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected", cycle_count,
				expected_readings.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Computes the result of one sample and advances the history and run state.
	function automatic out_t detect_approach(in_t item);
		logic [27:0] product;
		logic [DIST_W-1:0] sample_dist;
		longint sum, lhs, rhs;
		out_t r;
		product = item.adc_code * scale_q16;
		sample_dist = product[27] ? DIST_MAX : product[26:10];
		r.warning = 1'b0;
		if (!primed) begin
			for (int i = 0; i < HISTORY_DEPTH; i++)
				ring[i] = sample_dist;
			primed = 1'b1;
		end else begin
			sum = longint'(ring[0]) + longint'(ring[1]) + longint'(ring[2]);
			lhs = (sum - 3 * longint'(sample_dist)) * 1000;
			rhs = 192 * longint'(lim_rate) * longint'(item.elapsed_ms);
			ring[ring_slot] = sample_dist;
			ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
			if (lhs >= rhs) begin
				if (run_len != RUN_MAX)
					run_len++;
			end else begin
				run_len = '0;
			end
			r.warning = (sample_dist < lim_dist) && (run_len >= runs_needed);
		end
		r.distance = sample_dist;
		r.approach_run = run_len;
		return r;
	endfunction

	// Receiver: random stalls, plus one long hold-off counted here on request.
	initial begin : receiver
		int pause;
		int n;
		out_stall = 1'b0;
		hold_ack = 1'b0;
		pause = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_ack) begin
				out_stall = 1'b1;
				for (n = 0; n < LONG_HOLD; n++)
					@(negedge clk);
				hold_ack = 1'b1;
			end
			if (!hold_req)
				hold_ack = 1'b0;
			if (pause == 0)
				pause = pick_gap();
			if (pause > 0) begin
				out_stall = 1'b1;
				pause--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("Unexpected result: warning %0b distance %0d run %0d",
						out_data.warning, out_data.distance, out_data.approach_run);
			end else begin
				want = expected_readings.pop_front();
				results_checked++;
				if (out_data.warning === 1'b1)
					warnings_seen++;
				if (int'(out_data.approach_run) > longest_run)
					longest_run = int'(out_data.approach_run);
				if (out_data.warning !== want.warning || out_data.distance !== want.distance
						|| out_data.approach_run !== want.approach_run) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("Mismatch at result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
							results_checked, want.warning, want.distance, want.approach_run,
							out_data.warning, out_data.distance, out_data.approach_run);
				end
			end
		end
	end

	// One input transfer, followed by a random idle gap.
	task automatic send_reading(input logic [ADC_W-1:0] code,
			input logic [ELAPSED_W-1:0] ms);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		in_data.adc_code = code;
		in_data.elapsed_ms = ms;
		do
			@(posedge clk);
		while (in_stall);
		expected_readings.push_back(detect_approach(in_data));
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stops offering items and waits until every result has come back.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		settings_written++;
		case (idx)
			CFG_DIST_LIMIT: lim_dist = value[DIST_W-1:0];
			CFG_RATE_LIMIT: lim_rate = value[RATE_W-1:0];
			CFG_READINGS:   runs_needed = value[RUN_W-1:0];
			CFG_SCALE:      scale_q16 = value[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	// Random register settings with the extremes well represented.
	task automatic pick_settings();
		case ($urandom_range(0, 3))
			0: write_reg(CFG_DIST_LIMIT, '0);
			1: write_reg(CFG_DIST_LIMIT, CFG_W'(DIST_MAX));
			default: write_reg(CFG_DIST_LIMIT, CFG_W'($urandom_range(0, 131071)));
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(CFG_RATE_LIMIT, '0);
			1: write_reg(CFG_RATE_LIMIT, CFG_W'(1023));
			2, 3: write_reg(CFG_RATE_LIMIT, CFG_W'($urandom_range(0, 60)));
			default: write_reg(CFG_RATE_LIMIT, CFG_W'($urandom_range(0, 1023)));
		endcase
		case ($urandom_range(0, 5))
			0: write_reg(CFG_READINGS, '0);
			1: write_reg(CFG_READINGS, CFG_W'(RUN_MAX));
			2, 3: write_reg(CFG_READINGS, CFG_W'($urandom_range(1, 8)));
			default: write_reg(CFG_READINGS, CFG_W'($urandom_range(0, 255)));
		endcase
		case ($urandom_range(0, 4))
			0: write_reg(CFG_SCALE, '0);
			1: write_reg(CFG_SCALE, CFG_W'(16'hFFFF));
			default: write_reg(CFG_SCALE, CFG_W'($urandom_range(0, 65535)));
		endcase
	endtask

	// Mostly falling distance sequences with random content, some raw noise.
	// With pacing, the sender now and then waits for every result to return.
	task automatic send_mixed(input int count, input bit paced);
		int sent, len, code, step, k;
		logic [ELAPSED_W-1:0] ms;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 3) != 0) begin
				len = $urandom_range(3, 24);
				code = $urandom_range(0, 4095);
				step = $urandom_range(0, 120);
				for (k = 0; k < len; k++) begin
					ms = ($urandom_range(0, 7) == 0) ? ELAPSED_W'($urandom)
						: ELAPSED_W'($urandom_range(0, 150));
					send_reading(ADC_W'(code), ms);
					code = code - step;
					if ($urandom_range(0, 15) == 0)
						code = code + $urandom_range(0, 300);
					if (code < 0)
						code = 0;
					if (code > 4095)
						code = 4095;
				end
			end else begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++)
					send_reading(ADC_W'($urandom), ELAPSED_W'($urandom));
			end
			sent += len;
			if (paced && $urandom_range(0, 2) == 0)
				wait_idle();
		end
	endtask

	// Reset values: priming item, a steady approach up to a warning, a sudden
	// retreat and the field extremes.
	task automatic test_reset_defaults();
		int k;
		send_reading(12'd600, 16'd50);
		for (k = 1; k <= 5; k++)
			send_reading(ADC_W'(600 - 40 * k), 16'd50);
		send_reading(12'd0, 16'd1);
		send_reading(12'd4095, 16'hFFFF);
		send_reading(12'd4095, 16'd0);
		send_reading(12'd0, 16'd0);
	endtask

	// Saturated distance, zero rate limit, zero run requirement, then the
	// opposite extremes of every register.
	task automatic test_corner_settings();
		write_reg(CFG_SCALE, CFG_W'(16'hFFFF));
		write_reg(CFG_RATE_LIMIT, '0);
		write_reg(CFG_READINGS, '0);
		write_reg(CFG_DIST_LIMIT, CFG_W'(DIST_MAX));
		send_reading(12'd4095, 16'd100);
		send_reading(12'd4095, 16'd0);
		send_reading(12'd2000, 16'd0);
		send_reading(12'd0, 16'hFFFF);
		send_reading(12'd1, 16'd1);
		write_reg(CFG_DIST_LIMIT, '0);
		write_reg(CFG_RATE_LIMIT, CFG_W'(1023));
		write_reg(CFG_READINGS, CFG_W'(RUN_MAX));
		write_reg(CFG_SCALE, '0);
		send_reading(12'd4095, 16'hFFFF);
		send_reading(12'd0, 16'd0);
		send_reading(12'd0, 16'd1);
	endtask

	task automatic test_random_settings();
		int phase;
		for (phase = 0; phase < 6; phase++) begin
			pick_settings();
			steady = ($urandom_range(0, 3) == 0);
			send_mixed(210, 1'b0);
		end
		steady = 1'b0;
	endtask

	// A zero rate limit and non-rising distances drive the run to saturate at 255.
	task automatic test_run_saturation();
		int k, code;
		write_reg(CFG_RATE_LIMIT, '0);
		write_reg(CFG_READINGS, CFG_W'(RUN_MAX));
		write_reg(CFG_DIST_LIMIT, CFG_W'(DIST_MAX));
		write_reg(CFG_SCALE, CFG_W'($urandom_range(0, 65535)));
		code = 4095;
		for (k = 0; k < 300; k++) begin
			send_reading(ADC_W'(code), ELAPSED_W'($urandom));
			if ($urandom_range(0, 9) == 0)
				code = (code > 3) ? code - $urandom_range(0, 3) : 0;
		end
	endtask

	// The receiver holds off long enough for the block to stall its input.
	task automatic test_output_hold();
		pick_settings();
		hold_req = 1'b1;
		send_mixed(60, 1'b0);
		hold_req = 1'b0;
	endtask

	task automatic test_paced_stream();
		pick_settings();
		send_mixed(200, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_DIST_LIMIT;
		cfg_data = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++)
			ring[i] = '0;
		ring_slot = 0;
		run_len = '0;
		primed = 1'b0;
		lim_dist = DIST_LIMIT_RST;
		lim_rate = RATE_LIMIT_RST;
		runs_needed = READINGS_RST;
		scale_q16 = SCALE_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_corner_settings();
		test_random_settings();
		test_run_saturation();
		test_output_hold();
		test_paced_stream();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples, checked %0d results across %0d register writes.",
			items_sent, results_checked, settings_written);
		$display("Saw %0d warnings; longest approach run %0d; %0d mismatches.",
			warnings_seen, longest_run, mismatches);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
